### rtl/ctx_pkg.sv
// Shared types and constants for the counter timebase extender.
`timescale 1ns / 1ps
package ctx_pkg;

	localparam int unsigned TICK_SHIFT_DEF = 8;
	localparam int unsigned QUEUE_DEPTH    = 2;

	localparam int unsigned PERIOD_W  = 16;
	localparam int unsigned SAMPLE_W  = 16;
	localparam int unsigned TICKS_W   = 64;
	localparam int unsigned DIFF_W    = 32;
	localparam int unsigned COUNT_W   = 32;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [PERIOD_W-1:0] MAX_PERIOD_RST = 16'd11931;
	localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST = 16'd119;
	localparam logic [SAMPLE_W-1:0] SAMPLE_RELOAD  = 16'hFFFF;

	typedef enum logic {
		CMD_READ = 1'b0,
		CMD_SET  = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_PERIOD = 1'b0,
		REG_MIN_PERIOD = 1'b1
	} reg_idx_t;

	// classified item as it travels from front to back
	typedef struct packed {
		logic                is_set;
		logic [SAMPLE_W-1:0] sample;
		logic [DIFF_W-1:0]   want;
	} item_t;

endpackage

### rtl/ctx_if.sv
// Handshake channel interfaces: request, response and register write.
`timescale 1ns / 1ps
interface ctx_req_if;
	logic                           valid;
	logic                           ready;
	logic                           command;
	logic [ctx_pkg::SAMPLE_W-1:0]   counter_sample;
	logic [ctx_pkg::TICKS_W-1:0]    deadline;

	modport source (output valid, command, counter_sample, deadline, input ready);
	modport sink   (input valid, command, counter_sample, deadline, output ready);
endinterface

interface ctx_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [ctx_pkg::TICKS_W-1:0]    scaled_ticks;
	logic                           reload_counter;
	logic                           load_period;
	logic [ctx_pkg::PERIOD_W-1:0]   period_value;
	logic [ctx_pkg::COUNT_W-1:0]    period_change_count;

	modport source (output valid, scaled_ticks, reload_counter, load_period, period_value,
		period_change_count, input ready);
	modport sink   (input valid, scaled_ticks, reload_counter, load_period, period_value,
		period_change_count, output ready);
endinterface

interface ctx_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ctx_pkg::CFG_IDX_W-1:0]  index;
	logic [ctx_pkg::PERIOD_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### rtl/ctx_front.sv
// Front stage: takes request beats, classifies them and pre-shifts the deadline.
`timescale 1ns / 1ps
module ctx_front #(
	parameter int unsigned TICK_SHIFT = ctx_pkg::TICK_SHIFT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	ctx_req_if.sink         req,
	output logic            push,
	output ctx_pkg::item_t  push_item,
	input  logic            push_ready
);
	import ctx_pkg::*;

	logic  valid_s1;
	item_t item_s1;

	assign push      = valid_s1;
	assign push_item = item_s1;
	assign req.ready = !valid_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1.is_set <= (cmd_t'(req.command) == CMD_SET);
			item_s1.sample <= req.counter_sample;
			item_s1.want   <= DIFF_W'(req.deadline >> TICK_SHIFT);
		end
	end

endmodule

### rtl/ctx_queue.sv
// Short register queue between front and back.
`timescale 1ns / 1ps
module ctx_queue #(
	parameter int unsigned DEPTH = ctx_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ctx_pkg::item_t  push_item,
	output logic            push_ready,
	output logic            pop_valid,
	output ctx_pkg::item_t  pop_item,
	input  logic            pop
);
	import ctx_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	item_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1))
			return '0;
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_item;
	end

endmodule

### rtl/ctx_back.sv
// Back stage: timebase and period state, execution and response register.
`timescale 1ns / 1ps
module ctx_back #(
	parameter int unsigned TICK_SHIFT = ctx_pkg::TICK_SHIFT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  ctx_pkg::item_t  item,
	output logic            pop,
	ctx_cfg_if.sink         cfg,
	ctx_rsp_if.source       rsp
);
	import ctx_pkg::*;

	logic [PERIOD_W-1:0] max_period_q;
	logic [PERIOD_W-1:0] min_period_q;
	logic [SAMPLE_W-1:0] last_sample_q;
	logic [TICKS_W-1:0]  tick_total_q;
	logic [PERIOD_W-1:0] cur_period_q;
	logic [COUNT_W-1:0]  change_count_q;

	logic                rsp_valid_q;
	logic [TICKS_W-1:0]  scaled_ticks_q;
	logic                reload_q;
	logic                load_q;
	logic [PERIOD_W-1:0] period_q;
	logic [COUNT_W-1:0]  change_out_q;

	logic [SAMPLE_W-1:0] elapsed_raw;
	logic [SAMPLE_W-1:0] elapsed;
	logic [PERIOD_W+1:0] limit3;
	logic                runaway;
	logic [SAMPLE_W-1:0] next_sample;
	logic [TICKS_W-1:0]  next_ticks;
	logic [DIFF_W-1:0]   diff;
	logic [PERIOD_W-1:0] want_period;
	logic                ex_load;
	logic                ex_reload;
	logic [PERIOD_W-1:0] next_period;
	logic [COUNT_W-1:0]  next_count;

	assign pop = item_valid && (!rsp_valid_q || rsp.ready);
	assign cfg.ready = 1'b1;

	// both branches of the read reduce to a 16-bit wrapping subtract
	always_comb begin
		elapsed_raw = last_sample_q - item.sample;
		limit3      = {2'b00, max_period_q} + {1'b0, max_period_q, 1'b0};
		runaway     = (item.sample >= last_sample_q) &&
			({2'b00, elapsed_raw} > limit3);
		ex_reload   = !item.is_set && runaway;
		elapsed     = runaway ? cur_period_q : elapsed_raw;
		next_sample = runaway ? SAMPLE_RELOAD : item.sample;
		next_ticks  = tick_total_q + TICKS_W'(elapsed >> 1);

		diff = item.want - tick_total_q[DIFF_W-1:0];
		if (diff[DIFF_W-1] || diff < DIFF_W'(min_period_q))
			want_period = min_period_q;
		else if (diff > DIFF_W'(max_period_q))
			want_period = max_period_q;
		else
			want_period = diff[PERIOD_W-1:0];
		ex_load     = item.is_set && (want_period != cur_period_q);
		next_period = ex_load ? want_period : cur_period_q;
		next_count  = ex_load ? change_count_q + 1'b1 : change_count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_period_q   <= MAX_PERIOD_RST;
			min_period_q   <= MIN_PERIOD_RST;
			last_sample_q  <= '0;
			tick_total_q   <= '0;
			cur_period_q   <= MAX_PERIOD_RST;
			change_count_q <= '0;
			rsp_valid_q    <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (reg_idx_t'(cfg.index))
					REG_MAX_PERIOD: max_period_q <= cfg.data;
					REG_MIN_PERIOD: min_period_q <= cfg.data;
					default: ;
				endcase
			end
			if (pop) begin
				if (item.is_set) begin
					cur_period_q   <= next_period;
					change_count_q <= next_count;
				end else begin
					last_sample_q <= next_sample;
					tick_total_q  <= next_ticks;
				end
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			scaled_ticks_q <= (item.is_set ? tick_total_q : next_ticks) << TICK_SHIFT;
			reload_q       <= ex_reload;
			load_q         <= ex_load;
			period_q       <= next_period;
			change_out_q   <= next_count;
		end
	end

	assign rsp.valid               = rsp_valid_q;
	assign rsp.scaled_ticks        = scaled_ticks_q;
	assign rsp.reload_counter      = reload_q;
	assign rsp.load_period         = load_q;
	assign rsp.period_value        = period_q;
	assign rsp.period_change_count = change_out_q;

	a_count_tracks_load: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && ex_load) |=> (change_count_q == $past(change_count_q) + 1'b1))
		else $error("period change count did not advance on a load");

	a_set_keeps_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && item.is_set) |=> (tick_total_q == $past(tick_total_q)
			&& last_sample_q == $past(last_sample_q)))
		else $error("set beat disturbed the timebase");

	a_reload_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && ex_reload) |=> (last_sample_q == SAMPLE_RELOAD && rsp_valid_q && reload_q))
		else $error("reload did not force the sample");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp.ready) |=> (rsp_valid_q && $stable(scaled_ticks_q)))
		else $error("stalled response changed");

endmodule

### rtl/counter_timebase_extender_core.sv
// Top level of the counter timebase extender.
//
//  channel  dir  payload
//  req      in   command, counter_sample, deadline
//  rsp      out  scaled_ticks, reload_counter, load_period, period_value,
//                period_change_count
//  cfg      in   index (0 max_period, 1 min_period), data
//
// One beat per cycle sustained while rsp is ready; a request beat passes through the front
// register, the queue and the back response register before its response is valid.
// The back state update (16-bit subtract, clamp compares, 64-bit add) is combinational logic.
// Reset is asynchronous; no clearing pass, req.ready is already high at release.
// A stalled rsp fills the queue and then drops req.ready; cfg is always ready.
`timescale 1ns / 1ps
module counter_timebase_extender_core #(
	parameter int unsigned TICK_SHIFT  = ctx_pkg::TICK_SHIFT_DEF,
	parameter int unsigned QUEUE_DEPTH = ctx_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	ctx_req_if.sink     req,
	ctx_cfg_if.sink     cfg,
	ctx_rsp_if.source   rsp
);
	import ctx_pkg::*;

	logic  push;
	item_t push_item;
	logic  push_ready;
	logic  q_valid;
	item_t q_item;
	logic  pop;

	ctx_front #(.TICK_SHIFT(TICK_SHIFT)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	ctx_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (q_valid),
		.pop_item   (q_item),
		.pop        (pop)
	);

	ctx_back #(.TICK_SHIFT(TICK_SHIFT)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item       (q_item),
		.pop        (pop),
		.cfg        (cfg),
		.rsp        (rsp)
	);

endmodule
